@@ rtl/wpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

   localparam int TEXT_CHAR_W   = 5;
   localparam int PAT_LEN_W     = 6;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 3;
   localparam int SYMBOL_W      = 8;
   localparam int PATTERN_SLOTS = 32;

   localparam logic [SYMBOL_W-1:0] LETTER_COUNT = 8'd26;
   localparam logic [SYMBOL_W-1:0] SYM_QUESTION = 8'd26;
   localparam logic [SYMBOL_W-1:0] SYM_STAR     = 8'd27;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PATTERN_LENGTH = 3'd0,
      REG_SYMBOLS_0      = 3'd1,
      REG_SYMBOLS_1      = 3'd2,
      REG_SYMBOLS_2      = 3'd3,
      REG_SYMBOLS_3      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PAT_LEN_W-1:0]                    pattern_length;
      logic [PATTERN_SLOTS-1:0][SYMBOL_W-1:0]  symbols;
   } cfg_type;

   typedef struct packed {
      logic [TEXT_CHAR_W-1:0] text_char;
      logic                   end_of_text;
      logic                   empty_text;
   } req_payload_type;

   typedef struct packed {
      logic prefix_matches;
      logic is_last;
   } rsp_payload_type;

endpackage

@@ rtl/wpm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_req_if / wpm_rsp_if
// Valid/ready channels for text items and match results.
// ----------------------------------------------------------------------------
interface wpm_req_if
   import wpm_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [TEXT_CHAR_W-1:0] text_char;
   logic                   end_of_text;
   logic                   empty_text;

   modport source (output valid, output text_char, output end_of_text,
                   output empty_text, input ready);
   modport sink   (input valid, input text_char, input end_of_text,
                   input empty_text, output ready);
endinterface

interface wpm_rsp_if;
   logic valid;
   logic ready;
   logic prefix_matches;
   logic is_last;

   modport source (output valid, output prefix_matches, output is_last, input ready);
   modport sink   (input valid, input prefix_matches, input is_last, output ready);
endinterface

@@ rtl/wpm_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_csr
// Pattern length and pattern symbol registers, write-only port.
// ----------------------------------------------------------------------------
module wpm_csr
   import wpm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_PATTERN_LENGTH: cfg_in.pattern_length = csr_wdata[PAT_LEN_W-1:0];
            REG_SYMBOLS_0:      cfg_in.symbols[7:0]   = csr_wdata;
            REG_SYMBOLS_1:      cfg_in.symbols[15:8]  = csr_wdata;
            REG_SYMBOLS_2:      cfg_in.symbols[23:16] = csr_wdata;
            REG_SYMBOLS_3:      cfg_in.symbols[31:24] = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/wpm_row_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_row_update
// Next match row for one text item. The left-to-right dependency along the
// row is a generate/propagate chain, evaluated as one carry add.
// ----------------------------------------------------------------------------
module wpm_row_update
   import wpm_pkg::*;
#(
   parameter int MAX_PATTERN = 32
) (
   input  cfg_type                 cfg,
   input  req_payload_type         item,
   input  logic                    at_start,
   input  logic [MAX_PATTERN:0]    row_cur,
   output logic [MAX_PATTERN:0]    row_next,
   output logic                    matched
);

   localparam int RW = MAX_PATTERN + 1;
   localparam int NW = $clog2(MAX_PATTERN + 1);

   logic [NW-1:0]          n_used;
   logic [MAX_PATTERN-1:0] wild;
   logic [MAX_PATTERN-1:0] gen;
   logic [MAX_PATTERN-1:0] add_a;
   logic [RW-1:0]          empty_sum;
   logic [RW-1:0]          empty_row;
   logic [RW-1:0]          base_row;
   logic [RW-1:0]          adv_sum;
   logic [RW-1:0]          adv_row;

   always_comb begin
      if (cfg.pattern_length > PAT_LEN_W'(MAX_PATTERN)) begin
         n_used = NW'(MAX_PATTERN);
      end else begin
         n_used = NW'(cfg.pattern_length);
      end
   end

   // propagate terms: '?' and '*' within the used length
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         wild[k] = (NW'(k) < n_used) &&
                   (cfg.symbols[k] == SYM_QUESTION || cfg.symbols[k] == SYM_STAR);
      end
   end

   // empty-text row: bit 0 set, then carried through leading wildcards
   assign empty_sum = {1'b0, wild} + RW'(1);
   assign empty_row = empty_sum ^ {1'b0, wild};

   assign base_row = (at_start || item.empty_text) ? empty_row : row_cur;

   // generate terms from the previous row
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         gen[k] = 1'b0;
         if (NW'(k) < n_used) begin
            if (cfg.symbols[k] < LETTER_COUNT &&
                cfg.symbols[k] == {3'b000, item.text_char}) begin
               gen[k] = base_row[k];
            end else if (cfg.symbols[k] == SYM_QUESTION) begin
               gen[k] = base_row[k];
            end else if (cfg.symbols[k] == SYM_STAR) begin
               gen[k] = base_row[k+1];
            end
         end
      end
   end

   assign add_a   = gen | wild;
   assign adv_sum = {1'b0, add_a} + {1'b0, gen};
   assign adv_row = adv_sum ^ {1'b0, add_a ^ gen};

   assign row_next = item.empty_text ? empty_row : adv_row;
   assign matched  = row_next[n_used];

endmodule

@@ rtl/wildcard_pattern_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Streams text letters through a wildcard match row and reports per item
// whether the text so far matches the whole configured pattern.
//
// Path: input register, then result register; a stalled result holds the item in the input reg.
// Throughput: 1 item per cycle unless results stall; one carry add per item for the row.
// Reset: pattern registers cleared, match row cleared, next item starts a text.
// No clearing pass; items are accepted from the first cycle after reset.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher
   import wpm_pkg::*;
#(
   parameter int MAX_PATTERN = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   wpm_req_if.sink                req_chan,
   wpm_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type               cfg;
   req_payload_type       req_payload;
   req_payload_type       item_ff;
   logic                  item_valid_ff;
   logic                  item_valid_in;
   rsp_payload_type       rsp_ff;
   rsp_payload_type       rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [MAX_PATTERN:0]  row_ff;
   logic [MAX_PATTERN:0]  row_in;
   logic                  at_start_ff;
   logic                  at_start_in;
   logic [MAX_PATTERN:0]  row_next;
   logic                  matched;
   logic                  advance;
   logic                  req_fire;

   wpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wpm_row_update #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_row_update (
      .cfg      (cfg),
      .item     (item_ff),
      .at_start (at_start_ff),
      .row_cur  (row_ff),
      .row_next (row_next),
      .matched  (matched)
   );

   assign req_payload.text_char   = req_chan.text_char;
   assign req_payload.end_of_text = req_chan.end_of_text;
   assign req_payload.empty_text  = req_chan.empty_text;

   assign advance        = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      item_valid_in = item_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      row_in        = row_ff;
      at_start_in   = at_start_ff;
      if (req_fire) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in          = 1'b1;
         rsp_in.prefix_matches = matched;
         rsp_in.is_last        = item_ff.end_of_text || item_ff.empty_text;
         row_in                = row_next;
         at_start_in           = item_ff.end_of_text || item_ff.empty_text;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         row_ff        <= '0;
         at_start_ff   <= 1'b1;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         row_ff        <= row_in;
         at_start_ff   <= at_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.prefix_matches = rsp_ff.prefix_matches;
   assign rsp_chan.is_last        = rsp_ff.is_last;

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.empty_text) |=> (rsp_valid_ff && rsp_ff.is_last))
      else $error("empty-text item did not close the text");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.end_of_text) |=> at_start_ff)
      else $error("text end did not restart the row");

   a_row_origin: assert property (@(posedge clock) disable iff (reset)
      (advance && !item_ff.empty_text) |=> !row_ff[0])
      else $error("row origin bit set after a text letter");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && item_valid_ff) |=> item_valid_ff)
      else $error("item dropped while result stalled");

endmodule

@@ dv/wpm_match_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_match_checker
// Watches the text and result channels and the pattern register writes of the
// wildcard pattern matcher. It keeps its own match row and pattern copy,
// predicts one verdict per accepted text item, and compares each accepted
// result field by field with the oldest predicted verdict.
// ----------------------------------------------------------------------------
module wpm_match_checker
   import wpm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   wpm_req_if                     req_mon,
   wpm_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatches,
   output int                     outstanding,
   output int                     results_checked,
   output int                     full_hits
);

   localparam int MAX_PATTERN = 32;

   cfg_type           pattern_cfg;
   logic [32:0]       match_row;
   logic              text_fresh;
   rsp_payload_type   expected_verdicts [$];

   function automatic logic [5:0] active_length();
      if (pattern_cfg.pattern_length > MAX_PATTERN) begin
         return 6'(MAX_PATTERN);
      end
      return pattern_cfg.pattern_length;
   endfunction

   function automatic logic [32:0] empty_text_row(input logic [5:0] n);
      logic [32:0]         row;
      logic [SYMBOL_W-1:0] s;
      int                  j;
      row = '0;
      row[0] = 1'b1;
      for (j = 1; j <= n; j++) begin
         s = pattern_cfg.symbols[j-1];
         if ((s == SYM_QUESTION || s == SYM_STAR) && row[j-1]) begin
            row[j] = 1'b1;
         end
      end
      return row;
   endfunction

   function automatic logic [32:0] advance_row(input logic [32:0] prev, input logic [5:0] n,
                                                input logic [TEXT_CHAR_W-1:0] ch);
      logic [32:0]         row;
      logic [SYMBOL_W-1:0] s;
      int                  j;
      row = '0;
      for (j = 1; j <= n; j++) begin
         s = pattern_cfg.symbols[j-1];
         if (s < LETTER_COUNT && s == SYMBOL_W'(ch)) begin
            row[j] = prev[j-1];
         end else if (s == SYM_QUESTION) begin
            row[j] = prev[j-1] | row[j-1];
         end else if (s == SYM_STAR) begin
            row[j] = prev[j] | row[j-1];
         end
      end
      return row;
   endfunction

   function automatic rsp_payload_type next_verdict(input logic [TEXT_CHAR_W-1:0] ch,
                                                    input logic last, input logic empty);
      rsp_payload_type verdict;
      logic [5:0]      n;
      n = active_length();
      if (empty) begin
         match_row  = empty_text_row(n);
         text_fresh = 1'b1;
         verdict.prefix_matches = match_row[n];
         verdict.is_last        = 1'b1;
         return verdict;
      end
      if (text_fresh) begin
         match_row = empty_text_row(n);
      end
      match_row  = advance_row(match_row, n, ch);
      text_fresh = last;
      verdict.prefix_matches = match_row[n];
      verdict.is_last        = last;
      return verdict;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      int              b;
      if (reset) begin
         pattern_cfg = '0;
         match_row   = '0;
         text_fresh  = 1'b1;
         expected_verdicts.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_PATTERN_LENGTH: pattern_cfg.pattern_length = csr_wdata[PAT_LEN_W-1:0];
               REG_SYMBOLS_0, REG_SYMBOLS_1, REG_SYMBOLS_2, REG_SYMBOLS_3: begin
                  for (b = 0; b < 8; b++) begin
                     pattern_cfg.symbols[(csr_index - REG_SYMBOLS_0) * 8 + b] =
                        csr_wdata[b*8 +: 8];
                  end
               end
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_verdicts.push_back(next_verdict(req_mon.text_char, req_mon.end_of_text,
                                                     req_mon.empty_text));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.prefix_matches = rsp_mon.prefix_matches;
            got.is_last        = rsp_mon.is_last;
            results_checked++;
            if (got.prefix_matches === 1'b1 && got.is_last === 1'b1) begin
               full_hits++;
            end
            if (expected_verdicts.size() == 0) begin
               $error("unexpected item on result channel: prefix_matches %0b, is_last %0b",
                      got.prefix_matches, got.is_last);
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               if (got.prefix_matches !== want.prefix_matches) begin
                  $error("prefix_matches: expected %0b, actual %0b",
                         want.prefix_matches, got.prefix_matches);
                  mismatches++;
               end
               if (got.is_last !== want.is_last) begin
                  $error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
                  mismatches++;
               end
            end
         end
      end
      outstanding = expected_verdicts.size();
   end

endmodule

@@ dv/tb_wildcard_pattern_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_pattern_matcher
// Stimulus and verdict for the wildcard pattern matcher. Directed texts cover
// the empty pattern, zero-length '?', star runs, clamped length, unknown
// symbols, letters out of range and abandoned texts; random phases then load
// new patterns and stream texts built from them, with noise and cut texts.
// ----------------------------------------------------------------------------
module tb_wildcard_pattern_matcher;
   import wpm_pkg::*;

   localparam int RANDOM_ITEMS = 1550;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatches;
   int outstanding;
   int results_checked;
   int full_hits;
   int items_sent;
   int texts_sent;
   int settings_used;
   bit src_eager;

   logic [PAT_LEN_W-1:0]   pat_len;
   logic [SYMBOL_W-1:0]    pat_sym [PATTERN_SLOTS];
   logic [TEXT_CHAR_W-1:0] text_q [$];

   wpm_req_if req_chan ();
   wpm_rsp_if rsp_chan ();

   wildcard_pattern_matcher #(.MAX_PATTERN(32)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wpm_match_checker verdict_chk (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .full_hits       (full_hits)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int pick_gap(input bit eager);
      int r;
      if (eager) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // result side: runs of ready broken by stalls of random length
   initial begin
      int run_len;
      int stall;
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
         repeat (run_len) @(posedge clock);
         stall = pick_gap(1'b0);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   task automatic push_item(input logic [TEXT_CHAR_W-1:0] ch, input logic last,
                            input logic empty);
      int gap;
      bit seen;
      gap = pick_gap(src_eager);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.text_char   <= ch;
      req_chan.end_of_text <= last;
      req_chan.empty_text  <= empty;
      do begin
         @(negedge clock);
         seen = req_chan.ready;
         @(posedge clock);
      end while (!seen);
      items_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_pattern(input logic [PAT_LEN_W-1:0] len,
                               input logic [63:0] w0, input logic [63:0] w1,
                               input logic [63:0] w2, input logic [63:0] w3);
      logic [63:0] words [4];
      int          j;
      words[0] = w0;
      words[1] = w1;
      words[2] = w2;
      words[3] = w3;
      drain();
      write_reg(REG_PATTERN_LENGTH, CSR_DATA_W'(len));
      write_reg(REG_SYMBOLS_0, w0);
      write_reg(REG_SYMBOLS_1, w1);
      write_reg(REG_SYMBOLS_2, w2);
      write_reg(REG_SYMBOLS_3, w3);
      csr_we <= 1'b0;
      pat_len = len;
      for (j = 0; j < PATTERN_SLOTS; j++) begin
         pat_sym[j] = words[j/8][(j%8)*8 +: 8];
      end
      settings_used++;
   endtask

   function automatic logic [SYMBOL_W-1:0] roll_symbol();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return SYMBOL_W'($urandom_range(0, 3));
      if (r < 70) return SYM_QUESTION;
      if (r < 88) return SYM_STAR;
      if (r < 95) return SYMBOL_W'($urandom_range(0, 25));
      return SYMBOL_W'($urandom_range(28, 255));
   endfunction

   task automatic random_setting(input int phase);
      logic [PAT_LEN_W-1:0] len;
      logic [63:0]          w [4];
      int                   j;
      int                   r;
      r = $urandom_range(0, 99);
      case (phase)
         0:       len = 6'd32;
         1:       len = 6'd0;
         2:       len = PAT_LEN_W'($urandom_range(33, 63));
         default: begin
            if (r < 70)      len = PAT_LEN_W'($urandom_range(1, 8));
            else if (r < 90) len = PAT_LEN_W'($urandom_range(9, 32));
            else if (r < 95) len = PAT_LEN_W'($urandom_range(33, 63));
            else             len = 6'd0;
         end
      endcase
      for (j = 0; j < PATTERN_SLOTS; j++) begin
         w[j/8][(j%8)*8 +: 8] = (j < len) ? roll_symbol() : 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 9) == 0) begin
         w[$urandom_range(0, 3)] = {$urandom, $urandom};
      end
      load_pattern(len, w[0], w[1], w[2], w[3]);
   endtask

   // builds a text that mostly fits the loaded pattern, then maybe damages it
   task automatic build_text();
      int n;
      int j;
      int r;
      text_q.delete();
      n = (pat_len > 32) ? 32 : pat_len;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         repeat ($urandom_range(1, 8)) text_q.push_back(TEXT_CHAR_W'($urandom_range(0, 31)));
         return;
      end
      for (j = 0; j < n; j++) begin
         case (pat_sym[j])
            SYM_QUESTION: begin
               if ($urandom_range(0, 1)) text_q.push_back(TEXT_CHAR_W'($urandom_range(0, 3)));
            end
            SYM_STAR: repeat ($urandom_range(0, 3))
               text_q.push_back(TEXT_CHAR_W'($urandom_range(0, 3)));
            default: begin
               if (pat_sym[j] < LETTER_COUNT) text_q.push_back(pat_sym[j][TEXT_CHAR_W-1:0]);
               else text_q.push_back(TEXT_CHAR_W'($urandom_range(0, 25)));
            end
         endcase
      end
      if (r < 35 && text_q.size() > 0) begin
         text_q[$urandom_range(0, text_q.size() - 1)] = TEXT_CHAR_W'($urandom_range(0, 31));
      end else if (r < 45) begin
         text_q.push_back(TEXT_CHAR_W'($urandom_range(0, 3)));
      end else if (r < 52 && text_q.size() > 0) begin
         text_q.delete($urandom_range(0, text_q.size() - 1));
      end
   endtask

   // empty queue means an empty-text query; cut drops the end mark and closes with an empty-text query
   task automatic send_queued(input bit cut);
      int j;
      if (text_q.size() == 0) begin
         push_item(TEXT_CHAR_W'($urandom), 1'($urandom), 1'b1);
      end else begin
         for (j = 0; j < text_q.size(); j++) begin
            push_item(text_q[j], (j == text_q.size() - 1) && !cut, 1'b0);
         end
         if (cut) push_item(TEXT_CHAR_W'($urandom), 1'($urandom), 1'b1);
      end
      texts_sent++;
   endtask

   initial begin
      int phase;
      int random_start;
      int phase_end;
      req_chan.valid       = 1'b0;
      req_chan.text_char   = '0;
      req_chan.end_of_text = 1'b0;
      req_chan.empty_text  = 1'b0;
      csr_we               = 1'b0;
      csr_index            = REG_PATTERN_LENGTH;
      csr_wdata            = '0;
      pat_len              = '0;
      foreach (pat_sym[j]) pat_sym[j] = '0;
      src_eager            = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty pattern after reset
      text_q = {};
      send_queued(1'b0);
      text_q = '{5'd0};
      send_queued(1'b0);

      // a ? * z
      load_pattern(6'd4, 64'h00000000_191B1A00, 64'd0, 64'd0, 64'd0);
      text_q = '{5'd0, 5'd25};
      send_queued(1'b0);
      text_q = '{5'd0, 5'd1, 5'd25};
      send_queued(1'b0);
      text_q = '{5'd0, 5'd1, 5'd2, 5'd25};
      send_queued(1'b0);
      text_q = '{5'd31};
      send_queued(1'b0);
      text_q = '{5'd0};
      send_queued(1'b1);

      // length above the maximum, all stars
      load_pattern(6'd40, {8{8'h1B}}, {8{8'h1B}}, {8{8'h1B}}, {8{8'h1B}});
      text_q = {};
      send_queued(1'b0);
      text_q = '{5'd0, 5'd31};
      send_queued(1'b0);

      // unknown symbol code first
      load_pattern(6'd3, 64'h00000000_00001BC8, 64'd0, 64'd0, 64'd0);
      text_q = '{5'd0};
      send_queued(1'b0);
      text_q = {};
      send_queued(1'b0);

      // two question marks
      load_pattern(6'd2, 64'h00000000_00001A1A, 64'd0, 64'd0, 64'd0);
      text_q = {};
      send_queued(1'b0);
      text_q = '{5'd0, 5'd1};
      send_queued(1'b0);
      text_q = '{5'd0, 5'd1, 5'd2};
      send_queued(1'b0);

      random_start = items_sent;
      phase = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         random_setting(phase);
         src_eager = (phase % 4 == 3);
         phase_end = items_sent + $urandom_range(80, 160);
         while (items_sent < phase_end) begin
            build_text();
            send_queued($urandom_range(0, 19) == 0);
         end
         phase++;
      end
      src_eager = 1'b0;

      drain();
      @(negedge clock);
      $display("Sent %0d items in %0d texts under %0d pattern settings.",
               items_sent, texts_sent, settings_used);
      $display("Compared %0d results, %0d of them final full-pattern matches.",
               results_checked, full_hits);
      if (mismatches == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/wpm_pkg.sv
rtl/wpm_if.sv
rtl/wpm_csr.sv
rtl/wpm_row_update.sv
rtl/wildcard_pattern_matcher.sv
dv/wpm_match_checker.sv
dv/tb_wildcard_pattern_matcher.sv
